/* hdl/assert_macros.svh */
// Assertion macros used by the task selector engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle property violated");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle property violated");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* hdl/lwts_pkg.sv */
// Shared constants, types and helper functions of the longest-wait task selector.
`timescale 1ns / 1ps

package lwts_pkg;

    // Table geometry and field widths.
    localparam int SLOT_COUNT   = 16;
    localparam int ID_WIDTH     = 16;
    localparam int TIME_WIDTH   = 32;
    localparam int SLOT_W       = $clog2(SLOT_COUNT);
    localparam int KIND_W       = 2;
    localparam int STATUS_W     = 2;
    localparam int ID_FIELD_W   = 16;
    localparam int SLOT_FIELD_W = 4;

    // Scan counter end value and last slot index.
    localparam logic [SLOT_W:0]   SLOT_END = (SLOT_W + 1)'(SLOT_COUNT);
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOT_COUNT - 1);

    // Queue between the front end and the engine.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_YIELD  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SELECT = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NONE     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NO_MATCH = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [ID_WIDTH-1:0]   task_id;
        logic [TIME_WIDTH-1:0] stamp;
    } queue_item_t;

    typedef struct packed {
        logic [ID_WIDTH-1:0]   task_id;
        logic [TIME_WIDTH-1:0] stamp;
    } slot_entry_t;

    // Input id field to internal id width (kept modulo the internal width).
    function automatic logic [ID_WIDTH-1:0] to_int_id(input logic [ID_FIELD_W-1:0] id);
        logic [ID_WIDTH+ID_FIELD_W-1:0] ext;
        ext = {{ID_WIDTH{1'b0}}, id};
        return ext[ID_WIDTH-1:0];
    endfunction

    // Internal id to the output id field.
    function automatic logic [ID_FIELD_W-1:0] to_out_id(input logic [ID_WIDTH-1:0] id);
        logic [ID_WIDTH+ID_FIELD_W-1:0] ext;
        ext = {{ID_FIELD_W{1'b0}}, id};
        return ext[ID_FIELD_W-1:0];
    endfunction

    // Slot index to the output slot field, reported modulo its width.
    function automatic logic [SLOT_FIELD_W-1:0] to_slot_field(input logic [SLOT_W-1:0] s);
        logic [SLOT_W+SLOT_FIELD_W-1:0] ext;
        ext = {{SLOT_FIELD_W{1'b0}}, s};
        return ext[SLOT_FIELD_W-1:0];
    endfunction

endpackage

/* hdl/lwts_front.sv */
// Front end: accepts request words, advances the time counter and stamps each request.
`timescale 1ns / 1ps

module lwts_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [lwts_pkg::KIND_W-1:0]         kind,
    input  logic [lwts_pkg::ID_FIELD_W-1:0]     task_id,
    output logic                                push_valid,
    input  logic                                push_ready,
    output lwts_pkg::queue_item_t               push_data
);

    logic [lwts_pkg::TIME_WIDTH-1:0] time_now_reg;
    logic [lwts_pkg::TIME_WIDTH-1:0] time_now_next;
    logic                            accept;

    // Each accepted word sees the time after its own increment.
    assign time_now_next = time_now_reg + lwts_pkg::TIME_WIDTH'(1);
    assign in_ready      = push_ready;
    assign push_valid    = in_valid;
    assign accept        = in_valid && push_ready;

    assign push_data.kind    = kind;
    assign push_data.task_id = lwts_pkg::to_int_id(task_id);
    assign push_data.stamp   = time_now_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_now_reg <= '0;
        end
        else if (accept)
        begin
            time_now_reg <= time_now_next;
        end
    end

endmodule

/* hdl/lwts_queue.sv */
// Short first-in first-out queue between the front end and the engine.
`timescale 1ns / 1ps

module lwts_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  lwts_pkg::queue_item_t push_data,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output lwts_pkg::queue_item_t pop_data
);

    lwts_pkg::queue_item_t            store_reg [lwts_pkg::QUEUE_DEPTH];
    logic [lwts_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [lwts_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [lwts_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [lwts_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [lwts_pkg::QCNT_W-1:0]      count_reg;
    logic [lwts_pkg::QCNT_W-1:0]      count_next;
    logic                             do_push;
    logic                             do_pop;

    assign push_ready = (count_reg != lwts_pkg::QCNT_W'(lwts_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = store_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            if (wr_ptr_reg == lwts_pkg::QPTR_W'(lwts_pkg::QUEUE_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + lwts_pkg::QPTR_W'(1);
        end
        if (do_pop)
        begin
            if (rd_ptr_reg == lwts_pkg::QPTR_W'(lwts_pkg::QUEUE_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + lwts_pkg::QPTR_W'(1);
        end
        if (do_push && !do_pop)
            count_next = count_reg + lwts_pkg::QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - lwts_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hdl/lwts_engine.sv */
// Back end: holds the slot table, scans it once per request and drives the result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lwts_engine
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  pop_valid,
    output logic                                  pop_ready,
    input  lwts_pkg::queue_item_t                 pop_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [lwts_pkg::STATUS_W-1:0]         status,
    output logic [lwts_pkg::ID_FIELD_W-1:0]       chosen_id,
    output logic [lwts_pkg::SLOT_FIELD_W-1:0]     slot_index
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // Slot memory: task id and stamp; one write port, one registered read port.
    lwts_pkg::slot_entry_t slot_mem [lwts_pkg::SLOT_COUNT];
    lwts_pkg::slot_entry_t rd_data_reg;
    logic                              mem_re;
    logic [lwts_pkg::SLOT_W-1:0]       rd_addr;
    logic                              mem_we;
    logic [lwts_pkg::SLOT_W-1:0]       mem_waddr;
    lwts_pkg::slot_entry_t             mem_wdata;

    logic [1:0]                             state_reg, state_next;
    logic [lwts_pkg::KIND_W-1:0]            op_reg, op_next;
    logic [lwts_pkg::ID_WIDTH-1:0]          id_reg, id_next;
    logic [lwts_pkg::TIME_WIDTH-1:0]        time_reg, time_next;
    logic [lwts_pkg::SLOT_W:0]              cnt_reg, cnt_next;
    logic                                   eval_vld_reg, eval_vld_next;
    logic [lwts_pkg::SLOT_W-1:0]            eval_idx_reg, eval_idx_next;
    logic                                   found_reg, found_next;
    logic [lwts_pkg::SLOT_W-1:0]            pick_reg, pick_next;
    logic [lwts_pkg::TIME_WIDTH-1:0]        best_reg, best_next;
    logic [lwts_pkg::ID_WIDTH-1:0]          best_task_reg, best_task_next;
    logic [lwts_pkg::SLOT_COUNT-1:0]        slot_valid_reg, slot_valid_next;
    logic [lwts_pkg::SLOT_COUNT-1:0]        slot_busy_reg, slot_busy_next;
    logic                                   out_valid_reg, out_valid_next;
    logic [lwts_pkg::STATUS_W-1:0]          out_status_reg, out_status_next;
    logic [lwts_pkg::ID_FIELD_W-1:0]        out_chosen_reg, out_chosen_next;
    logic [lwts_pkg::SLOT_FIELD_W-1:0]      out_slot_reg, out_slot_next;

    logic                                   done_fire;
    logic                                   cur_valid;
    logic                                   cur_busy;
    logic                                   cur_match;
    logic [lwts_pkg::TIME_WIDTH-1:0]        elapsed;

    assign cur_valid = slot_valid_reg[eval_idx_reg];
    assign cur_busy  = slot_busy_reg[eval_idx_reg];
    assign cur_match = cur_valid && (rd_data_reg.task_id == id_reg);
    assign elapsed   = time_reg - rd_data_reg.stamp;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        time_next       = time_reg;
        cnt_next        = cnt_reg;
        eval_vld_next   = 1'b0;
        eval_idx_next   = cnt_reg[lwts_pkg::SLOT_W-1:0];
        found_next      = found_reg;
        pick_next       = pick_reg;
        best_next       = best_reg;
        best_task_next  = best_task_reg;
        slot_valid_next = slot_valid_reg;
        slot_busy_next  = slot_busy_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_chosen_next = out_chosen_reg;
        out_slot_next   = out_slot_reg;
        pop_ready       = 1'b0;
        mem_re          = 1'b0;
        rd_addr         = cnt_reg[lwts_pkg::SLOT_W-1:0];
        mem_we          = 1'b0;
        mem_waddr       = pick_reg;
        mem_wdata       = '{task_id: id_reg, stamp: time_reg};
        done_fire       = 1'b0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    op_next    = pop_data.kind;
                    id_next    = pop_data.task_id;
                    time_next  = pop_data.stamp;
                    cnt_next   = '0;
                    found_next = 1'b0;
                    pick_next  = '0;
                    best_next  = '0;
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // Reads are issued one slot a cycle; each is judged the cycle after.
                if (cnt_reg < lwts_pkg::SLOT_END)
                begin
                    mem_re        = 1'b1;
                    cnt_next      = cnt_reg + (lwts_pkg::SLOT_W + 1)'(1);
                    eval_vld_next = 1'b1;
                end
                if (eval_vld_reg)
                begin
                    unique case (op_reg)
                        lwts_pkg::KIND_ADD:
                        begin
                            if (!found_reg && !cur_valid)
                            begin
                                found_next = 1'b1;
                                pick_next  = eval_idx_reg;
                            end
                        end
                        lwts_pkg::KIND_REMOVE:
                        begin
                            if (cur_match)
                            begin
                                if (!found_reg)
                                    pick_next = eval_idx_reg;
                                found_next                    = 1'b1;
                                slot_valid_next[eval_idx_reg] = 1'b0;
                                slot_busy_next[eval_idx_reg]  = 1'b0;
                            end
                        end
                        lwts_pkg::KIND_YIELD:
                        begin
                            if (cur_match && !found_reg)
                            begin
                                found_next = 1'b1;
                                pick_next  = eval_idx_reg;
                            end
                        end
                        lwts_pkg::KIND_SELECT:
                        begin
                            if (cur_valid && !cur_busy && (elapsed > best_reg))
                            begin
                                found_next     = 1'b1;
                                pick_next      = eval_idx_reg;
                                best_next      = elapsed;
                                best_task_next = rd_data_reg.task_id;
                            end
                        end
                        default:
                        begin
                            found_next = found_reg;
                        end
                    endcase
                    if (eval_idx_reg == lwts_pkg::LAST_IDX)
                        state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    done_fire       = 1'b1;
                    out_valid_next  = 1'b1;
                    out_chosen_next = '0;
                    out_slot_next   = found_reg ? lwts_pkg::to_slot_field(pick_reg) : '0;
                    unique case (op_reg) inside
                        lwts_pkg::KIND_ADD:
                        begin
                            out_status_next = found_reg ? lwts_pkg::STATUS_OK
                                                        : lwts_pkg::STATUS_FULL;
                            if (found_reg)
                            begin
                                slot_valid_next[pick_reg] = 1'b1;
                                slot_busy_next[pick_reg]  = 1'b0;
                                mem_we                    = 1'b1;
                            end
                        end
                        lwts_pkg::KIND_REMOVE, lwts_pkg::KIND_YIELD:
                        begin
                            out_status_next = found_reg ? lwts_pkg::STATUS_OK
                                                        : lwts_pkg::STATUS_NO_MATCH;
                            if (found_reg && (op_reg == lwts_pkg::KIND_YIELD))
                                slot_busy_next[pick_reg] = 1'b0;
                        end
                        lwts_pkg::KIND_SELECT:
                        begin
                            out_status_next = found_reg ? lwts_pkg::STATUS_OK
                                                        : lwts_pkg::STATUS_NONE;
                            if (found_reg)
                            begin
                                slot_busy_next[pick_reg] = 1'b1;
                                mem_we                   = 1'b1;
                                mem_wdata                = '{task_id: best_task_reg,
                                                             stamp: time_reg};
                                out_chosen_next          = lwts_pkg::to_out_id(best_task_reg);
                            end
                        end
                        default:
                        begin
                            out_status_next = lwts_pkg::STATUS_NO_MATCH;
                        end
                    endcase
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            eval_vld_reg   <= 1'b0;
            found_reg      <= 1'b0;
            slot_valid_reg <= '0;
            slot_busy_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            eval_vld_reg   <= eval_vld_next;
            found_reg      <= found_next;
            slot_valid_reg <= slot_valid_next;
            slot_busy_reg  <= slot_busy_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        id_reg         <= id_next;
        time_reg       <= time_next;
        eval_idx_reg   <= eval_idx_next;
        pick_reg       <= pick_next;
        best_reg       <= best_next;
        best_task_reg  <= best_task_next;
        out_status_reg <= out_status_next;
        out_chosen_reg <= out_chosen_next;
        out_slot_reg   <= out_slot_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign chosen_id  = out_chosen_reg;
    assign slot_index = out_slot_reg;

    `ASSERT_NEXT(a_add_marks_valid, clk, rst_n, done_fire && (op_reg == lwts_pkg::KIND_ADD) && found_reg, slot_valid_reg[pick_reg] && !slot_busy_reg[pick_reg])
    `ASSERT_NEXT(a_grant_marks_busy, clk, rst_n, done_fire && (op_reg == lwts_pkg::KIND_SELECT) && found_reg, slot_valid_reg[pick_reg] && slot_busy_reg[pick_reg])
    `ASSERT_IMPLIES(a_judge_only_in_scan, clk, rst_n, eval_vld_reg, state_reg == ST_SCAN)
    `ASSERT_IMPLIES(a_failed_result_zero, clk, rst_n, out_valid_reg && (out_status_reg != lwts_pkg::STATUS_OK), (out_slot_reg == '0) && (out_chosen_reg == '0))

endmodule

/* hdl/longest_wait_task_selector_unit.sv */
// Top level of the longest-wait task selector: front end, request queue and engine.
`timescale 1ns / 1ps

// Usage notes.
// The block keeps a table of sixteen task slots and answers one request word on the input
// channel (in_valid, in_ready, kind, task_id) with exactly one result word on the output
// channel (out_valid, out_ready, status, chosen_id, slot_index). A word moves on a channel at
// a rising clock edge at which its valid and ready are both high.
// The front end advances the time counter on every accepted word and stamps the word with the
// new time, then places it in a two-entry queue. The engine takes one word at a time and
// walks the whole slot table through the single read port of the slot memory, one slot per
// cycle. A request that reaches the head of the queue, with the engine free, is taken from the
// queue and passes over the sixteen slots (the read is registered, so each slot is
// judged in the cycle after it is read); then, once the output register can take it, the
// table is updated and the result loaded. The engine takes the next word only after that, so
// the pass over the slot memory sets the sustained rate.
// When the receiver stalls, the result is held in the output register, the engine waits with
// its next result, and the queue goes on taking up to two further words.
// Reset (rst_n, asynchronous, active low) empties the queue, clears the time counter, marks
// every slot empty and idle and drops out_valid. No clearing pass is needed: ids and stamps
// are only used from slots marked valid.

module longest_wait_task_selector_unit
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [lwts_pkg::KIND_W-1:0]           kind,
    input  logic [lwts_pkg::ID_FIELD_W-1:0]       task_id,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [lwts_pkg::STATUS_W-1:0]         status,
    output logic [lwts_pkg::ID_FIELD_W-1:0]       chosen_id,
    output logic [lwts_pkg::SLOT_FIELD_W-1:0]     slot_index
);

    // Stamped requests on their way from the front end to the queue.
    logic                  push_valid;
    logic                  push_ready;
    lwts_pkg::queue_item_t push_data;

    // Requests leaving the queue for the engine.
    logic                  pop_valid;
    logic                  pop_ready;
    lwts_pkg::queue_item_t pop_data;

    // Front end: takes input words whenever the queue has room and keeps the time counter.
    lwts_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .task_id    (task_id),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // The queue lets the front end keep accepting while the engine is busy or stalled.
    lwts_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Engine: owns the slot table and the output register.
    lwts_engine u_engine
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .chosen_id  (chosen_id),
        .slot_index (slot_index)
    );

endmodule
